// File: hw/rtl/ptdm_pkg.sv
// Shared types, constants and command/status structs of the deadline monitor.
package ptdm_pkg;

  // Number of monitored tasks (1 to 5).
  localparam int TASK_COUNT = 5;
  localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

  // Configuration register file layout.
  localparam int NUM_PERIODS = 5;
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD1 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD2 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD3 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD4 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD5 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEST_LEN = 3'd5;
  localparam logic [31:0] PERIOD_RESET = 32'd10000;
  localparam logic [31:0] TEST_LEN_RESET = 32'd10000000;

  // Stream payload widths.
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 72;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_PERIODS-1:0] period_vec_t;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_JOB_START = 2'd1,
    OP_JOB_END   = 2'd2
  } op_e_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INIT,
    ST_EMIT
  } state_t;

  // Datapath commands.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_JOB_START,
    CMD_JOB_END,
    CMD_EMIT
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t           code;
    logic [IDX_W-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             task_ok;
    logic [IDX_W-1:0] task_idx;
    logic             timeout;
    logic             out_busy;
  } dp_sts_t;

endpackage

// File: hw/rtl/ptdm_regs.sv
// Configuration register file with the APB-style access port.
module ptdm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptdm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ptdm_pkg::period_vec_t      periods,
  output ptdm_pkg::word_t            test_length
);
  import ptdm_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PERIODS; k++) begin
        periods[k] <= PERIOD_RESET;
      end
      test_length <= TEST_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PERIOD1:  periods[0] <= pwdata;
        REG_PERIOD2:  periods[1] <= pwdata;
        REG_PERIOD3:  periods[2] <= pwdata;
        REG_PERIOD4:  periods[3] <= pwdata;
        REG_PERIOD5:  periods[4] <= pwdata;
        REG_TEST_LEN: test_length <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer; unmapped addresses read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_PERIOD1:  prdata = periods[0];
      REG_PERIOD2:  prdata = periods[1];
      REG_PERIOD3:  prdata = periods[2];
      REG_PERIOD4:  prdata = periods[3];
      REG_PERIOD5:  prdata = periods[4];
      REG_TEST_LEN: prdata = test_length;
      default:      prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/ptdm_dp.sv
// Datapath: captured item, per-task timing state, counters and result register.
module ptdm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ptdm_pkg::ctl_cmd_t            cmd,
  output ptdm_pkg::dp_sts_t             sts,
  input  logic [ptdm_pkg::IN_DATA_W-1:0] s_tdata,
  input  ptdm_pkg::period_vec_t         periods,
  input  ptdm_pkg::word_t               test_length,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ptdm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import ptdm_pkg::*;

  // Captured input transaction.
  logic [1:0] op_r;
  logic [2:0] req_r;
  word_t      now_r;
  word_t      start_time;

  // Per-task state, written by a start command before any read.
  word_t release_time  [TASK_COUNT];
  word_t next_deadline [TASK_COUNT];
  word_t jobs_done     [TASK_COUNT];
  word_t violations    [TASK_COUNT];

  // Result register fields.
  logic [2:0] out_task_id;
  word_t      out_viol;
  word_t      out_jobs;

  logic [2:0] req_minus1;
  word_t      elapsed;
  word_t      sel_period;
  word_t      sel_release;
  word_t      sel_deadline;

  assign req_minus1   = req_r - 3'd1;
  assign elapsed      = now_r - start_time;
  assign sel_period   = periods[cmd.idx];
  assign sel_release  = release_time[cmd.idx];
  assign sel_deadline = next_deadline[cmd.idx];

  // Status towards the controller.
  always_comb begin
    sts.op       = op_r;
    sts.task_ok  = (req_r != 3'd0) && (32'(req_r) <= 32'(TASK_COUNT));
    sts.task_idx = req_minus1[IDX_W-1:0];
    sts.timeout  = elapsed > test_length;
    sts.out_busy = m_tvalid && !m_tready;
  end

  // Item capture and start time.
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LOAD) begin
      op_r  <= s_tdata[1:0];
      req_r <= s_tdata[4:2];
      now_r <= s_tdata[36:5];
    end
    if (cmd.code == CMD_INIT) begin
      start_time <= now_r;
    end
  end

  // Per-task entry update, one entry per cycle.
  always_ff @(posedge clk) begin
    unique case (cmd.code)
      CMD_INIT: begin
        release_time[cmd.idx]  <= now_r;
        next_deadline[cmd.idx] <= now_r + sel_period;
        jobs_done[cmd.idx]     <= '0;
        violations[cmd.idx]    <= '0;
      end
      CMD_JOB_START: begin
        if (now_r < sel_release) begin
          violations[cmd.idx] <= violations[cmd.idx] + 32'd1;
        end
      end
      CMD_JOB_END: begin
        jobs_done[cmd.idx] <= jobs_done[cmd.idx] + 32'd1;
        if (now_r > sel_deadline) begin
          violations[cmd.idx] <= violations[cmd.idx] + 32'd1;
        end
        release_time[cmd.idx]  <= sel_deadline;
        next_deadline[cmd.idx] <= sel_deadline + sel_period;
      end
      default: ;
    endcase
  end

  // Output register: loaded on emit, held until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.code == CMD_EMIT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_EMIT) begin
      out_task_id <= 3'(cmd.idx) + 3'd1;
      out_viol    <= violations[cmd.idx];
      out_jobs    <= jobs_done[cmd.idx];
      m_tlast     <= (cmd.idx == LAST_IDX);
    end
  end

  assign m_tdata = {5'd0, out_jobs, out_viol, out_task_id};

endmodule

// File: hw/rtl/ptdm_ctrl.sv
// Controller state machine: decodes items and sequences the task sweeps.
module ptdm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  ptdm_pkg::dp_sts_t  sts,
  output ptdm_pkg::ctl_cmd_t cmd
);
  import ptdm_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             active;
  logic             active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      active <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      active <= active_next;
    end
  end

  // Next state, sweep index and active flag.
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    active_next = active;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        idx_next   = '0;
        state_next = ST_IDLE;
        if (sts.op == OP_START) begin
          active_next = 1'b1;
          state_next  = ST_INIT;
        end else if (active && sts.op == OP_JOB_START && sts.timeout) begin
          active_next = 1'b0;
          state_next  = ST_EMIT;
        end
      end
      ST_INIT: begin
        idx_next = idx + 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          idx_next = idx + 1'b1;
          if (idx == LAST_IDX) begin
            idx_next   = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath and the input handshake.
  always_comb begin
    s_tready = 1'b0;
    cmd.code = CMD_NONE;
    cmd.idx  = idx;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.code = CMD_LOAD;
        end
      end
      ST_DECODE: begin
        cmd.idx = sts.task_idx;
        if (active && sts.task_ok) begin
          if (sts.op == OP_JOB_START && !sts.timeout) begin
            cmd.code = CMD_JOB_START;
          end else if (sts.op == OP_JOB_END) begin
            cmd.code = CMD_JOB_END;
          end
        end
      end
      ST_INIT: cmd.code = CMD_INIT;
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.code = CMD_EMIT;
        end
      end
      default: ;
    endcase
  end

  // An accepted transaction is always decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_DECODE)
    else $error("accepted transaction not decoded");

  // A start command arms the monitor and sweeps from the first task.
  a_start_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECODE && sts.op == OP_START) |=> (state == ST_INIT && idx == '0 && active))
    else $error("start command did not begin the initialisation sweep");

  // The last summary result leaves the monitor inactive and idle.
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.code == CMD_EMIT && idx == LAST_IDX) |=> (state == ST_IDLE && !active))
    else $error("summary sweep did not finish cleanly");

  // Sweep index stays within the task table.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT || state == ST_EMIT) |-> idx <= LAST_IDX)
    else $error("sweep index out of range");

endmodule

// File: hw/rtl/periodic_task_deadline_monitor.sv
// Top level of the periodic task deadline monitor.
//
// Channel   Direction  Transfer condition            Payload
// s_*       in         s_tvalid & s_tready           operation, task_req, now
// m_*       out        m_tvalid & m_tready           task_id, violation_count, job_count, last
// APB       in         psel & penable & pwrite       period_task1..5, test_length
//
// A job event is captured in the idle state and updates its task entry in the decode state.
// A start command is captured, decoded, then initialises the task entries in turn.
// A timeout emits one summary result per cycle over the five task entries, pausing
// while m_tready is low; the single shared entry port of the task table sets this pace.
// The input is refused while a sweep runs; a result waits in the output register.
// Reset clears the controller and output valid; task entries are written by a start.
module periodic_task_deadline_monitor (
  input  logic                            clk,
  input  logic                            rst,
  // operation, task_req, now from bit 0, zero filled to 40 bits
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ptdm_pkg::IN_DATA_W-1:0]  s_tdata,
  // task_id, violation_count, job_count from bit 0, zero filled to 72 bits
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ptdm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptdm_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ptdm_pkg::*;

  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  period_vec_t periods;
  word_t       test_length;

  ptdm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .periods     (periods),
    .test_length (test_length)
  );

  ptdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptdm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .s_tdata     (s_tdata),
    .periods     (periods),
    .test_length (test_length),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
